@@ sv/ira_pkg.sv @@
// Package for the interval resource allocator: shared types and constants.
// No dependencies; the controller, datapath and top level import it.
package ira_pkg;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned OUT_W  = 11;

    // One-hot controller states.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_CHECK   = 10'b0000000010,
        S_RELEASE = 10'b0000000100,
        S_DN_RD   = 10'b0000001000,
        S_DN_CMP  = 10'b0000010000,
        S_ASSIGN  = 10'b0000100000,
        S_UP_RD   = 10'b0001000000,
        S_UP_CMP  = 10'b0010000000,
        S_DONE    = 10'b0100000000,
        S_WAIT    = 10'b1000000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new transaction
        logic rd_root;   // read heap root
        logic release_root; // push root id to free stack, move last entry to root
        logic dn_rd;     // read both children of the sift-down position
        logic dn_cmp;    // compare and swap for sift-down
        logic assign_id; // take an id and insert into heap
        logic up_rd;     // read parent of the sift-up position
        logic up_cmp;    // compare and swap for sift-up
        logic emit;      // present the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_expired; // heap not empty and root end below start
        logic dn_more;      // sift-down swapped and must go on
        logic up_more;      // sift-up swapped and must go on
        logic heap_added;   // assignment pushed an entry
    } t_status;
endpackage

@@ sv/interval_resource_allocator_top.sv @@
// Interval resource allocator: one transaction (start, end) at a time, taken
// when start is high and busy low; one result strobe per transaction, which
// the receiver cannot hold off. Each released entry adds a release step and
// a sift-down through the heap; an accepted transaction then takes an insert
// and a sift-up, while one refused for lack of capacity goes straight to the
// result. The result strobe is registered from the done state and rises when
// busy is already low. The walk through the heap memory takes one registered
// read step and one write step per level.
module interval_resource_allocator_top
    import ira_pkg::*;
#(
    parameter int unsigned MAX_RESOURCES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [TIME_W-1:0] i_start_time,
    input  logic [TIME_W-1:0] i_end_time,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_resource_id,
    output logic [OUT_W-1:0]  o_resources_used,
    output logic              o_overflow
);
    t_cmd    l_cmd;
    t_status l_status;

    ira_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy,
        .i_status(l_status), .o_cmd(l_cmd)
    );

    ira_dpath #(
        .MAX_RESOURCES(MAX_RESOURCES),
        .IDX_W($clog2(MAX_RESOURCES)),
        .CNT_W($clog2(MAX_RESOURCES) + 1)
    ) u_dpath (
        .i_clk, .i_rst_n, .i_cmd(l_cmd),
        .i_start_time, .i_end_time,
        .o_status(l_status), .o_valid, .o_resource_id,
        .o_resources_used, .o_overflow
    );
endmodule

@@ sv/ira_ctrl.sv @@
// Controller state machine of the interval resource allocator.
// Depends on ira_pkg for the state, command and status types.
module ira_ctrl
    import ira_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            S_WAIT: begin
                o_cmd.rd_root = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.root_expired) begin
                    n_state = S_RELEASE;
                end else begin
                    n_state = S_ASSIGN;
                end
            end
            S_RELEASE: begin
                o_cmd.release_root = 1'b1;
                n_state            = S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.dn_rd = 1'b1;
                n_state     = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                if (i_status.dn_more) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_ASSIGN: begin
                o_cmd.assign_id = 1'b1;
                if (i_status.heap_added) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP_RD: begin
                o_cmd.up_rd = 1'b1;
                n_state     = S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                if (i_status.up_more) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> r_state == S_WAIT)
        else $error("transaction not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("result not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RELEASE |=> r_state == S_DN_RD)
        else $error("release without sift-down");
endmodule

@@ sv/ira_dpath.sv @@
// Datapath of the interval resource allocator: heap memory, free stack
// memory, counters and comparators. Depends on ira_pkg.
module ira_dpath
    import ira_pkg::*;
#(
    parameter int unsigned MAX_RESOURCES = 1024,
    parameter int unsigned IDX_W = 10,
    parameter int unsigned CNT_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [TIME_W-1:0] i_start_time,
    input  logic [TIME_W-1:0] i_end_time,
    output t_status           o_status,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_resource_id,
    output logic [OUT_W-1:0]  o_resources_used,
    output logic              o_overflow
);
    localparam int unsigned ENT_W = TIME_W + CNT_W;

    // Heap entry: end time above, id below; a plain compare orders (end, id).
    logic [ENT_W-1:0] r_heap [MAX_RESOURCES];
    logic [CNT_W-1:0] r_stack [MAX_RESOURCES];

    logic [TIME_W-1:0] r_start, r_end;
    logic [CNT_W-1:0]  r_heap_cnt, r_sp, r_created;
    logic [CNT_W-1:0]  r_pos;        // current sift position
    logic [ENT_W-1:0]  r_rd_a, r_rd_b; // registered reads
    logic [ENT_W-1:0]  r_cur;        // entry being sifted
    logic [CNT_W-1:0]  r_stack_rd;
    logic              r_lv, r_rv;
    logic              r_valid, r_ovf;
    logic [CNT_W-1:0]  r_id;

    logic [CNT_W:0]   l_child, l_child_r;
    logic [CNT_W-1:0] l_parent;
    logic [CNT_W-1:0] l_last;
    logic [CNT_W-1:0] l_sp_top;
    logic             l_pick_r;
    logic [ENT_W-1:0] l_small;
    logic             l_dn_swap, l_up_swap;
    logic             l_can_free, l_can_new;
    logic [CNT_W-1:0] l_new_id;
    logic [ENT_W-1:0] l_ins;

    assign l_child    = {r_pos, 1'b1};
    assign l_child_r  = l_child + 1'b1;
    assign l_parent   = (r_pos - 1'b1) >> 1;
    assign l_last     = r_heap_cnt - 1'b1;
    assign l_sp_top   = r_sp - 1'b1;

    // The sifted entry sits in a hole; each step moves one entry into it,
    // so the heap memory takes a single write per cycle.
    assign l_pick_r   = r_rv && (r_rd_b < r_rd_a);
    assign l_small    = l_pick_r ? r_rd_b : r_rd_a;
    assign l_dn_swap  = r_lv && (l_small < r_cur);
    assign l_up_swap  = (r_pos != '0) && (r_cur < r_rd_a);
    assign l_can_free = (r_sp != '0);
    assign l_can_new  = (r_created < CNT_W'(MAX_RESOURCES));
    assign l_new_id   = l_can_free ? r_stack_rd : r_created + 1'b1;
    assign l_ins      = {r_end, l_new_id};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_start_time;
            r_end   <= i_end_time;
        end
        if (i_cmd.rd_root) begin
            r_rd_a     <= r_heap[0];
            r_stack_rd <= r_stack[l_sp_top[IDX_W-1:0]];
        end
        if (i_cmd.release_root) begin
            r_stack[r_sp[IDX_W-1:0]] <= r_rd_a[CNT_W-1:0];
            r_cur <= r_heap[l_last[IDX_W-1:0]];
        end
        if (i_cmd.dn_rd) begin
            r_rd_a <= r_heap[l_child[IDX_W-1:0]];
            r_rd_b <= r_heap[l_child_r[IDX_W-1:0]];
            r_lv   <= (l_child < {1'b0, r_heap_cnt});
            r_rv   <= (l_child_r < {1'b0, r_heap_cnt});
        end
        if (i_cmd.dn_cmp) begin
            r_heap[r_pos[IDX_W-1:0]] <= l_dn_swap ? l_small : r_cur;
        end
        if (i_cmd.assign_id) begin
            r_cur <= l_ins;
        end
        if (i_cmd.up_rd) begin
            r_rd_a <= r_heap[l_parent[IDX_W-1:0]];
        end
        if (i_cmd.up_cmp) begin
            r_heap[r_pos[IDX_W-1:0]] <= l_up_swap ? r_rd_a : r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_cnt <= '0;
            r_sp       <= '0;
            r_created  <= '0;
            r_pos      <= '0;
            r_valid    <= 1'b0;
            r_ovf      <= 1'b0;
            r_id       <= '0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.release_root) begin
                r_sp       <= r_sp + 1'b1;
                r_heap_cnt <= r_heap_cnt - 1'b1;
                r_pos      <= '0;
            end
            if (i_cmd.dn_cmp && l_dn_swap) begin
                r_pos <= l_pick_r ? CNT_W'(l_child_r) : CNT_W'(l_child);
            end
            if (i_cmd.assign_id) begin
                r_ovf <= !(l_can_free || l_can_new);
                if (l_can_free) begin
                    r_sp       <= r_sp - 1'b1;
                    r_id       <= l_new_id;
                    r_pos      <= r_heap_cnt;
                    r_heap_cnt <= r_heap_cnt + 1'b1;
                end else if (l_can_new) begin
                    r_created  <= r_created + 1'b1;
                    r_id       <= l_new_id;
                    r_pos      <= r_heap_cnt;
                    r_heap_cnt <= r_heap_cnt + 1'b1;
                end else begin
                    r_id <= '0;
                end
            end
            if (i_cmd.up_cmp && l_up_swap) begin
                r_pos <= l_parent;
            end
        end
    end

    assign o_status.root_expired = (r_heap_cnt != '0) && (r_rd_a[ENT_W-1:CNT_W] < r_start);
    assign o_status.dn_more      = l_dn_swap;
    assign o_status.up_more      = l_up_swap;
    assign o_status.heap_added   = l_can_free || l_can_new;

    assign o_valid          = r_valid;
    assign o_resource_id    = OUT_W'(r_id);
    assign o_resources_used = OUT_W'(r_created);
    assign o_overflow       = r_ovf;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp + r_heap_cnt) == r_created)
        else $error("busy and free ids do not add up to the created ids");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_created <= CNT_W'(MAX_RESOURCES))
        else $error("more ids created than the capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
endmodule
